// ===== hdl/seq_pkg.sv =====
package seq_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_BITS = 16;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int GROUP = 8;
  localparam int NGROUPS = (CAPACITY + GROUP - 1) / GROUP;

  localparam int ACT_W = 3;
  localparam int KEY_W = 16;
  localparam int TIME_W = 64;
  localparam int POS_W = 6;
  localparam int STAT_W = 2;
  localparam int COUNT_W = 7;

  localparam logic [ACT_W-1:0] ACT_INSERT       = 3'd0;
  localparam logic [ACT_W-1:0] ACT_UPDATE       = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE_FIRST = 3'd2;
  localparam logic [ACT_W-1:0] ACT_REMOVE_AT    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_FIND_KEY     = 3'd4;
  localparam logic [ACT_W-1:0] ACT_READ_AT      = 3'd5;

  typedef enum logic [STAT_W-1:0] {
    ST_OK,
    ST_FULL,
    ST_NOT_FOUND,
    ST_BAD
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MATCH,
    S_FIRST,
    S_GATHER,
    S_COLLECT,
    S_INSERT,
    S_FINISH
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_INS_TAIL,
    OP_INS_TIE,
    OP_REMOVE,
    OP_MATCH,
    OP_FIRST,
    OP_SEL_POS,
    OP_GATHER,
    OP_COLLECT,
    OP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             full;
    logic             pos_bad;
    logic             match_none;
  } dp_stat_t;

  typedef struct packed {
    status_t             status;
    logic [COUNT_W-1:0]  entry_count;
    logic [KEY_W-1:0]    min_key;
    logic [TIME_W-1:0]   min_time;
    logic [KEY_W-1:0]    hit_key;
    logic [TIME_W-1:0]   hit_time;
    logic [POS_W-1:0]    hit_position;
  } result_t;

endpackage

// ===== hdl/seq_req_if.sv =====
interface seq_req_if;
  logic                        valid;
  logic                        ready;
  logic [seq_pkg::ACT_W-1:0]   action;
  logic [seq_pkg::KEY_W-1:0]   key;
  logic [seq_pkg::TIME_W-1:0]  event_time;
  logic [seq_pkg::POS_W-1:0]   position;

  modport source (output valid, action, key, event_time, position, input ready);
  modport sink (input valid, action, key, event_time, position, output ready);
endinterface

// ===== hdl/seq_rsp_if.sv =====
interface seq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [seq_pkg::STAT_W-1:0]   status;
  logic [seq_pkg::COUNT_W-1:0]  entry_count;
  logic [seq_pkg::KEY_W-1:0]    min_key;
  logic [seq_pkg::TIME_W-1:0]   min_time;
  logic [seq_pkg::KEY_W-1:0]    hit_key;
  logic [seq_pkg::TIME_W-1:0]   hit_time;
  logic [seq_pkg::POS_W-1:0]    hit_position;

  modport source (output valid, status, entry_count, min_key, min_time, hit_key, hit_time,
                  hit_position, input ready);
  modport sink (input valid, status, entry_count, min_key, min_time, hit_key, hit_time,
                hit_position, output ready);
endinterface

// ===== hdl/seq_ctrl.sv =====
module seq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  seq_pkg::dp_stat_t stat,
  output seq_pkg::dp_cmd_t  cmd
);
  import seq_pkg::*;

  ctrl_state_t state, state_next;
  status_t     res_status, res_status_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_status <= ST_OK;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
      out_valid  <= out_valid_next;
    end
  end

  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    out_valid_next  = out_valid & ~out_ready;
    in_ready        = 1'b0;
    cmd.op          = OP_NOP;
    cmd.status      = res_status;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op          = OP_LOAD;
          res_status_next = ST_OK;
          state_next      = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_FINISH;
        case (stat.action)
          ACT_INSERT: begin
            if (stat.full) res_status_next = ST_FULL;
            else cmd.op = OP_INS_TAIL;
          end
          ACT_UPDATE, ACT_FIND_KEY: begin
            cmd.op     = OP_MATCH;
            state_next = S_MATCH;
          end
          ACT_REMOVE_FIRST, ACT_REMOVE_AT: begin
            if (stat.pos_bad) res_status_next = ST_BAD;
            else cmd.op = OP_REMOVE;
          end
          ACT_READ_AT: begin
            if (stat.pos_bad) begin
              res_status_next = ST_BAD;
            end else begin
              cmd.op     = OP_SEL_POS;
              state_next = S_GATHER;
            end
          end
          default: res_status_next = ST_BAD;
        endcase
      end
      S_MATCH: begin
        if (stat.match_none) begin
          res_status_next = ST_NOT_FOUND;
          state_next      = S_FINISH;
        end else begin
          cmd.op     = OP_FIRST;
          state_next = S_FIRST;
        end
      end
      S_FIRST: begin
        if (stat.action == ACT_UPDATE) begin
          cmd.op     = OP_REMOVE;
          state_next = S_INSERT;
        end else begin
          cmd.op     = OP_GATHER;
          state_next = S_COLLECT;
        end
      end
      S_GATHER: begin
        cmd.op     = OP_GATHER;
        state_next = S_COLLECT;
      end
      S_COLLECT: begin
        cmd.op     = OP_COLLECT;
        state_next = S_FINISH;
      end
      S_INSERT: begin
        cmd.op     = OP_INS_TIE;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.op         = OP_RESULT;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hdl/seq_dp.sv =====
module seq_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  seq_pkg::dp_cmd_t              cmd,
  input  logic [seq_pkg::ACT_W-1:0]     in_action,
  input  logic [seq_pkg::KEY_W-1:0]     in_key,
  input  logic [seq_pkg::TIME_W-1:0]    in_time,
  input  logic [seq_pkg::POS_W-1:0]     in_position,
  output seq_pkg::dp_stat_t             stat,
  output seq_pkg::result_t              result
);
  import seq_pkg::*;

  logic [KEY_BITS-1:0] keys [CAPACITY];
  logic [TIME_W-1:0]   times [CAPACITY];
  logic [KEY_BITS-1:0] keys_next [CAPACITY];
  logic [TIME_W-1:0]   times_next [CAPACITY];
  logic [CNT_W-1:0]    count, count_next;

  logic [ACT_W-1:0]    req_action;
  logic [KEY_BITS-1:0] req_key;
  logic [TIME_W-1:0]   req_time;
  logic [POS_W-1:0]    req_pos;
  logic [IDX_W-1:0]    p;

  logic [CAPACITY-1:0] match, match_next;
  logic [CAPACITY-1:0] first_hot;
  logic [IDX_W-1:0]    first_idx;
  logic [CAPACITY-1:0] sel, sel_pos;
  logic [CAPACITY-1:0] gt;
  logic [CAPACITY:0]   gt_below;
  logic                tie_en;

  logic [KEY_BITS-1:0] grp_key [NGROUPS];
  logic [TIME_W-1:0]   grp_time [NGROUPS];
  logic [KEY_BITS-1:0] grp_key_next [NGROUPS];
  logic [TIME_W-1:0]   grp_time_next [NGROUPS];
  logic [KEY_BITS-1:0] coll_key;
  logic [TIME_W-1:0]   coll_time;

  logic [KEY_BITS-1:0] hit_key;
  logic [TIME_W-1:0]   hit_time;
  logic [POS_W-1:0]    hit_pos;

  logic [POS_W-1:0]    load_pos;

  assign stat.action     = req_action;
  assign stat.full       = (count == CNT_W'(CAPACITY));
  assign stat.pos_bad    = (32'(req_pos) >= 32'(count));
  assign stat.match_none = (match == '0);

  assign load_pos  = (in_action == ACT_REMOVE_FIRST) ? '0 : in_position;
  assign first_hot = match & (~match + CAPACITY'(1));
  assign tie_en    = (cmd.op == OP_INS_TIE);
  assign gt_below  = {gt, 1'b0};

  always_comb begin
    first_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_hot[i]) first_idx = first_idx | IDX_W'(i);
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_next[i] = (CNT_W'(i) < count) && (keys[i] == req_key);
      sel_pos[i]    = (IDX_W'(i) == p);
      gt[i]         = (CNT_W'(i) < count) &&
                      ((times[i] > req_time) ||
                       (tie_en && times[i] == req_time && IDX_W'(i) >= p));
    end
  end

  always_comb begin
    keys_next  = keys;
    times_next = times;
    count_next = count;
    case (cmd.op)
      OP_INS_TAIL, OP_INS_TIE: begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (gt_below[i]) begin
            keys_next[i]  = keys[i-1];
            times_next[i] = times[i-1];
          end else if (gt[i] || CNT_W'(i) == count) begin
            keys_next[i]  = req_key;
            times_next[i] = req_time;
          end
        end
        count_next = count + CNT_W'(1);
      end
      OP_REMOVE: begin
        for (int i = 0; i < CAPACITY - 1; i++) begin
          if (IDX_W'(i) >= p) begin
            keys_next[i]  = keys[i+1];
            times_next[i] = times[i+1];
          end
        end
        count_next = count - CNT_W'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int g = 0; g < NGROUPS; g++) begin
      grp_key_next[g]  = '0;
      grp_time_next[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < CAPACITY) begin
          if (sel[g*GROUP+k]) begin
            grp_key_next[g]  = grp_key_next[g] | keys[g*GROUP+k];
            grp_time_next[g] = grp_time_next[g] | times[g*GROUP+k];
          end
        end
      end
    end
  end

  always_comb begin
    coll_key  = '0;
    coll_time = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      coll_key  = coll_key | grp_key[g];
      coll_time = coll_time | grp_time[g];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    keys  <= keys_next;
    times <= times_next;
    case (cmd.op)
      OP_LOAD: begin
        req_action <= in_action;
        req_key    <= KEY_BITS'(in_key);
        req_time   <= in_time;
        req_pos    <= load_pos;
        p          <= IDX_W'(load_pos);
        hit_key    <= '0;
        hit_time   <= '0;
        hit_pos    <= '0;
      end
      OP_MATCH: match <= match_next;
      OP_FIRST: begin
        p   <= first_idx;
        sel <= first_hot;
      end
      OP_SEL_POS: sel <= sel_pos;
      OP_GATHER: begin
        grp_key  <= grp_key_next;
        grp_time <= grp_time_next;
      end
      OP_COLLECT: begin
        hit_key  <= coll_key;
        hit_time <= coll_time;
        hit_pos  <= POS_W'(p);
      end
      OP_RESULT: begin
        result.status       <= cmd.status;
        result.entry_count  <= COUNT_W'(count);
        result.min_key      <= (count != '0) ? KEY_W'(keys[0]) : '0;
        result.min_time     <= (count != '0) ? times[0] : '0;
        result.hit_key      <= KEY_W'(hit_key);
        result.hit_time     <= hit_time;
        result.hit_position <= hit_pos;
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/sorted_event_time_queue.sv =====
// Sorted event-time queue: holds up to 64 (key, time) entries in ascending
// time order, stable among equal times, in a row of registers that compare
// and shift in parallel.
// req carries one operation per transaction (action, key, event_time,
// position); rsp returns exactly one result per operation with status,
// entry count after the operation, the minimum entry and the hit fields.
// Each operation is loaded on accept and then runs through the controller's
// steps before the result register: insert, remove, full, bad position and
// undefined action go straight to the result; update or find_key with an
// unknown key add a key match; read_at adds a position select and a two-level
// gather; find_key and update add a key match and first-match select, then a
// two-level gather for finds or a remove plus a tie-aware insert for updates.
// A new transaction is taken only once the controller is back in its idle state.
// The result sits in an output register; a new request is taken while it
// waits. If rsp stalls, the next result is held in the datapath until the
// output register frees, and req is not ready meanwhile.
// Reset (rst, synchronous, active high) empties the queue and drops any
// pending result; the entry storage itself needs no clearing.
module sorted_event_time_queue (
  input logic clk,
  input logic rst,
  seq_req_if.sink   req,
  seq_rsp_if.source rsp
);
  import seq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  result_t  result;

  seq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_ready (rsp.ready),
    .out_valid (rsp.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  seq_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_action   (req.action),
    .in_key      (req.key),
    .in_time     (req.event_time),
    .in_position (req.position),
    .stat        (stat),
    .result      (result)
  );

  assign rsp.status       = result.status;
  assign rsp.entry_count  = result.entry_count;
  assign rsp.min_key      = result.min_key;
  assign rsp.min_time     = result.min_time;
  assign rsp.hit_key      = result.hit_key;
  assign rsp.hit_time     = result.hit_time;
  assign rsp.hit_position = result.hit_position;

endmodule

// ===== sim/sorted_event_time_queue_tb.sv =====
module sorted_event_time_queue_tb;
  import seq_pkg::*;

  class queue_tracker;
    logic [KEY_W-1:0]  key_at[CAPACITY];
    logic [TIME_W-1:0] time_at[CAPACITY];
    int unsigned       held;
    result_t           pending_results[$];
    int unsigned       failures;

    function new();
      held = 0;
      failures = 0;
    endfunction

    function int first_with_key(logic [KEY_W-1:0] key);
      for (int i = 0; i < held; i++) begin
        if (key_at[i] == key) return i;
      end
      return -1;
    endfunction

    function void drop_entry(int p);
      for (int i = p + 1; i < held; i++) begin
        key_at[i-1] = key_at[i];
        time_at[i-1] = time_at[i];
      end
      held--;
    endfunction

    // Place an entry at slot dst, shifting the tail up by one.
    function void place_entry(int dst, logic [KEY_W-1:0] key, logic [TIME_W-1:0] t);
      for (int i = held; i > dst; i--) begin
        key_at[i] = key_at[i-1];
        time_at[i] = time_at[i-1];
      end
      key_at[dst] = key;
      time_at[dst] = t;
      held++;
    endfunction

    function void apply_request(logic [ACT_W-1:0] action, logic [KEY_W-1:0] key,
                                logic [TIME_W-1:0] t, logic [POS_W-1:0] pos);
      result_t r;
      int where;
      int dst;
      logic [KEY_W-1:0] moved_key;
      r = '0;
      r.status = ST_OK;
      where = -1;
      case (action)
        ACT_INSERT: begin
          if (held >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            dst = 0;
            while (dst < held && time_at[dst] <= t) dst++;
            place_entry(dst, key, t);
          end
        end
        ACT_UPDATE: begin
          where = first_with_key(key);
          if (where < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            // Reinsert stably: after equal times that sat before it, ahead of later ones.
            moved_key = key_at[where];
            drop_entry(where);
            dst = 0;
            for (int i = 0; i < held; i++) begin
              if (time_at[i] < t || (time_at[i] == t && i < where)) dst++;
            end
            place_entry(dst, moved_key, t);
          end
          where = -1;
        end
        ACT_REMOVE_FIRST: begin
          if (held == 0) r.status = ST_BAD;
          else drop_entry(0);
        end
        ACT_REMOVE_AT: begin
          if (pos >= held) r.status = ST_BAD;
          else drop_entry(pos);
        end
        ACT_FIND_KEY: begin
          where = first_with_key(key);
          if (where < 0) r.status = ST_NOT_FOUND;
        end
        ACT_READ_AT: begin
          if (pos >= held) r.status = ST_BAD;
          else where = pos;
        end
        default: r.status = ST_BAD;
      endcase
      if (where >= 0) begin
        r.hit_key = key_at[where];
        r.hit_time = time_at[where];
        r.hit_position = POS_W'(where);
      end
      r.entry_count = COUNT_W'(held);
      if (held != 0) begin
        r.min_key = key_at[0];
        r.min_time = time_at[0];
      end
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_response(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        failures++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("entry_count", want.entry_count, got.entry_count);
      compare_field("min_key", want.min_key, got.min_key);
      compare_field("min_time", want.min_time, got.min_time);
      compare_field("hit_key", want.hit_key, got.hit_key);
      compare_field("hit_time", want.hit_time, got.hit_time);
      compare_field("hit_position", want.hit_position, got.hit_position);
    endfunction
  endclass

  typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_t;

  localparam int RANDOM_ITEMS = 1250;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic no_idle = 1'b0;

  queue_tracker tracker = new();

  seq_req_if req_bus();
  seq_rsp_if rsp_bus();

  sorted_event_time_queue u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  always #2 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return {32'($urandom_range(0, 12)), 32'h0};
    if (r < 50) return {32'($urandom_range(0, 12)), 32'($urandom)};
    if (r < 75) return {32'($urandom), 32'($urandom)};
    if (r < 85) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    if (tracker.held == 0) return {32'($urandom_range(0, 12)), 32'h0};
    return tracker.time_at[$urandom_range(0, tracker.held - 1)];
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return KEY_W'($urandom_range(0, 15));
    if (r < 75 && tracker.held != 0) return tracker.key_at[$urandom_range(0, tracker.held - 1)];
    if (r < 85) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return KEY_W'($urandom);
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    if (tracker.held != 0 && $urandom_range(0, 99) < 75) begin
      return POS_W'($urandom_range(0, tracker.held - 1));
    end
    return POS_W'($urandom_range(0, 63));
  endfunction

  function automatic logic [ACT_W-1:0] pick_action(traffic_mode_t mode);
    logic [ACT_W-1:0] ops[6];
    int unsigned r;
    ops = '{ACT_INSERT, ACT_UPDATE, ACT_REMOVE_FIRST, ACT_REMOVE_AT, ACT_FIND_KEY, ACT_READ_AT};
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        if (r < 80) return ACT_INSERT;
        return ops[$urandom_range(1, 5)];
      end
      MODE_DRAIN: begin
        if (r < 35) return ACT_REMOVE_FIRST;
        if (r < 65) return ACT_REMOVE_AT;
        if (r < 75) return ACT_INSERT;
        if (r < 83) return ACT_UPDATE;
        if (r < 91) return ACT_FIND_KEY;
        return ACT_READ_AT;
      end
      default: begin
        if (r < 3) return ACT_W'($urandom_range(6, 7));
        return ops[$urandom_range(0, 5)];
      end
    endcase
  endfunction

  task automatic send_request(input logic [ACT_W-1:0] action, input logic [KEY_W-1:0] key,
                              input logic [TIME_W-1:0] t, input logic [POS_W-1:0] pos);
    int unsigned gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.action <= action;
    req_bus.key <= key;
    req_bus.event_time <= t;
    req_bus.position <= pos;
    do @(posedge clk); while (!req_bus.ready);
    tracker.apply_request(action, key, t, pos);
  endtask

  initial begin
    int unsigned on_len;
    int unsigned stall;
    forever begin
      on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 30);
      rsp_bus.ready <= 1'b1;
      repeat (on_len) @(posedge clk);
      stall = pick_gap();
      if (stall != 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      got.status = status_t'(rsp_bus.status);
      got.entry_count = rsp_bus.entry_count;
      got.min_key = rsp_bus.min_key;
      got.min_time = rsp_bus.min_time;
      got.hit_key = rsp_bus.hit_key;
      got.hit_time = rsp_bus.hit_time;
      got.hit_position = rsp_bus.hit_position;
      tracker.check_response(got);
    end
  end

  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    traffic_mode_t mode;
    int unsigned sent;
    int unsigned block_len;
    req_bus.valid <= 1'b0;
    req_bus.action <= ACT_INSERT;
    req_bus.key <= '0;
    req_bus.event_time <= '0;
    req_bus.position <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty store errors
    send_request(ACT_REMOVE_FIRST, 16'h0, 64'h0, 6'd0);
    send_request(ACT_READ_AT, 16'h0, 64'h0, 6'd0);
    send_request(ACT_FIND_KEY, 16'h5, 64'h0, 6'd0);
    send_request(ACT_UPDATE, 16'h5, 64'h1, 6'd0);
    send_request(ACT_REMOVE_AT, 16'h0, 64'h0, 6'd0);
    // extremes, ties and duplicate keys
    send_request(ACT_INSERT, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63);
    send_request(ACT_INSERT, 16'h0000, 64'h0, 6'd0);
    send_request(ACT_INSERT, 16'h0007, {32'd100, 32'h0}, 6'd0);
    send_request(ACT_INSERT, 16'h0007, {32'd100, 32'h0}, 6'd0);
    send_request(ACT_INSERT, 16'h0009, {32'd100, 32'h0}, 6'd0);
    send_request(ACT_FIND_KEY, 16'h0007, 64'h0, 6'd0);
    send_request(ACT_UPDATE, 16'h0009, 64'h0, 6'd0);
    send_request(ACT_UPDATE, 16'hFFFF, 64'h0, 6'd0);
    send_request(ACT_UPDATE, 16'h0007, {32'd100, 32'h0}, 6'd0);
    send_request(ACT_READ_AT, 16'h0, 64'h0, 6'd63);
    send_request(ACT_READ_AT, 16'h0, 64'h0, 6'd2);
    send_request(ACT_REMOVE_AT, 16'h0, 64'h0, 6'd4);
    send_request(ACT_REMOVE_AT, 16'h0, 64'h0, 6'd63);
    send_request(3'd6, 16'h1234, 64'h1, 6'd1);
    send_request(3'd7, 16'hFFFF, '1, 6'd63);
    send_request(ACT_REMOVE_FIRST, 16'h0, 64'h0, 6'd0);
    send_request(ACT_FIND_KEY, 16'hABCD, 64'h0, 6'd0);
    send_request(ACT_INSERT, 16'hAAAA, 64'h5555_5555_5555_5555, 6'd21);
    send_request(ACT_READ_AT, 16'h0, 64'h0, 6'd0);

    sent = 0;
    mode = MODE_FILL;
    block_len = 110;
    while (sent < RANDOM_ITEMS) begin
      no_idle <= ($urandom_range(0, 3) == 0);
      repeat (block_len) begin
        send_request(pick_action(mode), pick_key(), pick_time(), pick_position());
        sent++;
      end
      mode = traffic_mode_t'($urandom_range(0, 2));
      block_len = $urandom_range(20, 120);
    end
    req_bus.valid <= 1'b0;

    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sorted_event_time_queue.f =====
hdl/seq_pkg.sv
hdl/seq_req_if.sv
hdl/seq_rsp_if.sv
hdl/seq_ctrl.sv
hdl/seq_dp.sv
hdl/sorted_event_time_queue.sv
sim/sorted_event_time_queue_tb.sv
